// ----- src/rmat_pkg.sv -----
`default_nettype none

package rmat_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [30:0] value_in;
      logic        load_end;
      logic [9:0]  range_low;
      logic [9:0]  range_high;
   } req_type;

   typedef struct packed {
      logic signed [31:0] max_value;
      logic [9:0]         max_position;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [31:0] value;
      logic [9:0]  position;
   } node_type;

   localparam node_type PAD_NODE  = '{value: 32'hFFFF_FFFF, position: 10'd0};
   localparam node_type ZERO_NODE = '{value: 32'd0, position: 10'd0};

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic qry_init;
      logic build_rd;
      logic build_wr;
      logic qry_rd;
      logic qry_cmb;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic load_end;
      logic build_last;
      logic q_empty;
      logic q_done;
   } stat_type;

endpackage

`default_nettype wire

// ----- src/range_max_argmax_tree_core.sv -----
// A load word is written to its leaf slot after acceptance; the word that ends a load set
// then starts the bottom-up build: per internal node, read both children, write the larger.
// A query reads the left and right boundary nodes of each tree level visited and folds them
// into the running maxima; both read ports of the node memory serve one level at once.
// The result is shown for exactly one cycle and the receiver cannot stall it.
// Synchronous reset clears the controller, the load count, the tree-ready flag and the result strobe.
`default_nettype none

module range_max_argmax_tree_core #(
   parameter int LEAVES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rmat_pkg::req_type req_data,
   output rmat_pkg::rsp_type      rsp_data,
   output logic                   rsp_valid
);

   rmat_pkg::cmd_type  cmd;
   rmat_pkg::stat_type stat;

   rmat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rmat_dp #(
      .LEAVES (LEAVES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

`ifndef SYNTHESIS
   a_cmd_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word shown for more than one cycle");

   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a query in progress");

   a_accept_quiet : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result word directly after acceptance");
`endif

endmodule

`default_nettype wire

// ----- src/rmat_ctrl.sv -----
`default_nettype none

module rmat_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire rmat_pkg::stat_type stat,
   output rmat_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_BUILD_RD,
      S_BUILD_WR,
      S_QRY_RD,
      S_QRY_CMB,
      S_QRY_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_query) begin
               cmd.qry_init = 1'b1;
               state_in     = stat.q_empty ? S_QRY_DONE : S_QRY_RD;
            end else begin
               cmd.load_wr = 1'b1;
               state_in    = stat.load_end ? S_BUILD_RD : S_IDLE;
            end
         end
         S_BUILD_RD: begin
            cmd.build_rd = 1'b1;
            state_in     = S_BUILD_WR;
         end
         S_BUILD_WR: begin
            cmd.build_wr = 1'b1;
            state_in     = stat.build_last ? S_IDLE : S_BUILD_RD;
         end
         S_QRY_RD: begin
            cmd.qry_rd = 1'b1;
            state_in   = stat.q_done ? S_QRY_DONE : S_QRY_CMB;
         end
         S_QRY_CMB: begin
            cmd.qry_cmb = 1'b1;
            state_in    = S_QRY_RD;
         end
         S_QRY_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ----- src/rmat_dp.sv -----
`default_nettype none

module rmat_dp #(
   parameter int LEAVES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rmat_pkg::req_type req_data,
   input  wire rmat_pkg::cmd_type cmd,
   output rmat_pkg::stat_type     stat,
   output rmat_pkg::rsp_type      rsp_data,
   output logic                   rsp_valid
);

   localparam int LEAF_AW = $clog2(LEAVES);
   localparam int TREE_W  = 1 << LEAF_AW;
   localparam int NODE_AW = LEAF_AW + 1;
   localparam int DEPTH   = 2 * TREE_W;
   localparam int QW      = NODE_AW + 1;
   localparam int CNT_W   = $clog2(LEAVES + 2);
   localparam int XW      = (CNT_W > 10) ? CNT_W : 10;

   rmat_pkg::node_type node_mem [DEPTH];

   rmat_pkg::req_type  req_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ready_ff, ready_in;
   logic [LEAF_AW-1:0] node_ff, node_in;
   logic [QW-1:0]      l_ff, l_in;
   logic [QW-1:0]      r_ff, r_in;
   logic               take_l_ff, take_r_ff;
   rmat_pkg::node_type acc_l_ff, acc_l_in;
   rmat_pkg::node_type acc_r_ff, acc_r_in;
   logic               acc_l_ok_ff, acc_l_ok_in;
   logic               acc_r_ok_ff, acc_r_ok_in;
   rmat_pkg::node_type rd_a_ff, rd_b_ff;
   logic               pad_a_ff, pad_a_in;
   logic               pad_b_ff, pad_b_in;
   rmat_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic [CNT_W-1:0]   n_cnt;
   logic [CNT_W-1:0]   load_idx;
   logic               load_room;
   logic               overflow;
   logic [XW-1:0]      lo_x, hi_x, hi_c;
   logic               q_empty;
   logic [QW-1:0]      r_dec;
   logic [NODE_AW-1:0] addr_a, addr_b;
   logic               mem_we, mem_re;
   logic [NODE_AW-1:0] mem_waddr;
   rmat_pkg::node_type mem_wdata;
   rmat_pkg::node_type node_a, node_b, fin;
   logic               a_gt_b;

   always_comb begin
      n_cnt     = (count_ff > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : count_ff;
      overflow  = (count_ff > CNT_W'(LEAVES));
      load_idx  = ready_ff ? '0 : count_ff;
      load_room = (load_idx < CNT_W'(LEAVES));
      lo_x      = XW'(req_ff.range_low);
      hi_x      = XW'(req_ff.range_high);
      q_empty   = !ready_ff || (lo_x > hi_x) || (lo_x >= XW'(LEAVES));
      hi_c      = (hi_x > XW'(LEAVES - 1)) ? XW'(LEAVES - 1) : hi_x;
      r_dec     = r_ff - QW'(1);

      if (cmd.build_rd) begin
         addr_a = {node_ff, 1'b0};
         addr_b = {node_ff, 1'b1};
      end else begin
         addr_a = l_ff[NODE_AW-1:0];
         addr_b = r_dec[NODE_AW-1:0];
      end
      mem_re   = cmd.build_rd || cmd.qry_rd;
      pad_a_in = addr_a[NODE_AW-1] && (XW'(addr_a[LEAF_AW-1:0]) >= XW'(n_cnt));
      pad_b_in = addr_b[NODE_AW-1] && (XW'(addr_b[LEAF_AW-1:0]) >= XW'(n_cnt));

      node_a = pad_a_ff ? rmat_pkg::PAD_NODE : rd_a_ff;
      node_b = pad_b_ff ? rmat_pkg::PAD_NODE : rd_b_ff;
      a_gt_b = ($signed(node_a.value) > $signed(node_b.value));

      if (cmd.build_wr) begin
         mem_we    = 1'b1;
         mem_waddr = {1'b0, node_ff};
         mem_wdata = a_gt_b ? node_a : node_b;
      end else begin
         mem_we    = cmd.load_wr && load_room;
         mem_waddr = {1'b1, load_idx[LEAF_AW-1:0]};
         mem_wdata = '{value: {1'b0, req_ff.value_in}, position: 10'(load_idx)};
      end

      count_in    = count_ff;
      ready_in    = ready_ff;
      node_in     = node_ff;
      l_in        = l_ff;
      r_in        = r_ff;
      acc_l_in    = acc_l_ff;
      acc_r_in    = acc_r_ff;
      acc_l_ok_in = acc_l_ok_ff;
      acc_r_ok_in = acc_r_ok_ff;

      if (cmd.load_wr) begin
         count_in = load_room ? (load_idx + CNT_W'(1)) : CNT_W'(LEAVES + 1);
         ready_in = 1'b0;
         node_in  = '1;
      end
      if (cmd.build_wr) begin
         node_in = node_ff - LEAF_AW'(1);
         if (node_ff == LEAF_AW'(1)) begin
            ready_in = 1'b1;
         end
      end
      if (cmd.qry_init) begin
         l_in        = QW'(TREE_W) + QW'(lo_x);
         r_in        = QW'(TREE_W) + QW'(hi_c) + QW'(1);
         acc_l_ok_in = 1'b0;
         acc_r_ok_in = 1'b0;
      end
      if (cmd.qry_cmb) begin
         if (take_l_ff && (!acc_l_ok_ff ||
                           !($signed(acc_l_ff.value) > $signed(node_a.value)))) begin
            acc_l_in = node_a;
         end
         if (take_r_ff && (!acc_r_ok_ff ||
                           ($signed(node_b.value) > $signed(acc_r_ff.value)))) begin
            acc_r_in = node_b;
         end
         acc_l_ok_in = acc_l_ok_ff || take_l_ff;
         acc_r_ok_in = acc_r_ok_ff || take_r_ff;
         l_in        = (l_ff + QW'(take_l_ff)) >> 1;
         r_in        = (r_ff - QW'(take_r_ff)) >> 1;
      end

      if (q_empty) begin
         fin = rmat_pkg::ZERO_NODE;
      end else if (acc_l_ok_ff &&
                   (!acc_r_ok_ff || ($signed(acc_l_ff.value) > $signed(acc_r_ff.value)))) begin
         fin = acc_l_ff;
      end else if (acc_r_ok_ff) begin
         fin = acc_r_ff;
      end else begin
         fin = rmat_pkg::ZERO_NODE;
      end
      rsp_in = '{max_value: $signed(fin.value), max_position: fin.position,
                 overflow: overflow};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_a_ff <= node_mem[addr_a];
         rd_b_ff <= node_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (mem_re) begin
         pad_a_ff <= pad_a_in;
         pad_b_ff <= pad_b_in;
      end
      if (cmd.qry_rd) begin
         take_l_ff <= l_ff[0];
         take_r_ff <= r_ff[0];
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
      node_ff     <= node_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
      acc_l_ok_ff <= acc_l_ok_in;
      acc_r_ok_ff <= acc_r_ok_in;
   end

   always_comb begin
      stat.is_query   = (req_ff.operation == rmat_pkg::OP_QUERY);
      stat.load_end   = req_ff.load_end;
      stat.build_last = (node_ff == LEAF_AW'(1));
      stat.q_empty    = q_empty;
      stat.q_done     = !(l_ff < r_ff);
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
